>>> src/occupancy_box_inflation_top_assert.svh
// Assertion macros for the occupancy box inflation block
`ifndef OCCUPANCY_BOX_INFLATION_TOP_ASSERT_SVH
`define OCCUPANCY_BOX_INFLATION_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define OBI_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Implication checked on the edge after the antecedent
`define OBI_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

>>> src/obi_pkg.sv
// ----------------------------------------------------------------------------
// obi_pkg
// Types and constants shared by the occupancy box inflation block.
// ----------------------------------------------------------------------------
package obi_pkg;
    localparam int SizeS = 64;
    localparam int SizeL = 32;
    localparam int SizeT = 32;

    localparam logic [1:0] FUNC_WRITE   = 2'd0;
    localparam logic [1:0] FUNC_INFLATE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;

    localparam logic [2:0] REG_STEP_S_POS = 3'd0;
    localparam logic [2:0] REG_STEP_S_NEG = 3'd1;
    localparam logic [2:0] REG_STEP_L_POS = 3'd2;
    localparam logic [2:0] REG_STEP_L_NEG = 3'd3;
    localparam logic [2:0] REG_STEP_T_POS = 3'd4;
    localparam logic [2:0] REG_MAX_TSPAN  = 3'd5;

    typedef struct packed {
        logic [1:0] func;
        logic [5:0] a_s;
        logic [4:0] a_l;
        logic [4:0] a_t;
        logic [5:0] b_s;
        logic [4:0] b_l;
        logic [4:0] b_t;
        logic       occupied;
        logic [6:0] s_upper_limit;
        logic [5:0] s_lower_limit;
    } t_in_item;

    typedef struct packed {
        logic [5:0] box_s_low;
        logic [5:0] box_s_high;
        logic [4:0] box_l_low;
        logic [4:0] box_l_high;
        logic [4:0] box_t_low;
        logic [4:0] box_t_high;
        logic       seed_blocked;
    } t_out_item;
endpackage

>>> src/obi_ram.sv
// ----------------------------------------------------------------------------
// obi_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module obi_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> src/occupancy_box_inflation_top.sv
// ----------------------------------------------------------------------------
// occupancy_box_inflation_top
// Occupancy grid with seed box check and box inflation.
// ----------------------------------------------------------------------------
// The grid is held one voxel per RAM word with a registered read.
// After reset the block sweeps the whole grid free, with busy high, before
// the first transfer is taken. A write keeps busy high through its set-up
// state; a clear keeps it high through set-up and the same full sweep. An
// inflate reads the seed box and then each candidate plane one voxel per
// cycle, stopping a plane at its first occupied voxel. Each plane has a
// set-up state, each scan a read-drain state (skipped on an early hit) and a
// decision state; a plane outside the grid goes from set-up to decision. Each
// end of a side's turn and of a t pass has a state, as do set-up and output.
// The single result appears on o_done and o_result for one cycle, in the
// cycle in which busy drops, and cannot be held off.
// Write the step registers only while busy is low.
module occupancy_box_inflation_top #(
    parameter int SIZE_S = obi_pkg::SizeS,
    parameter int SIZE_L = obi_pkg::SizeL,
    parameter int SIZE_T = obi_pkg::SizeT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  obi_pkg::t_in_item i_item,
    output logic              o_done,
    output obi_pkg::t_out_item o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [6:0]        i_cfg_data
);
    import obi_pkg::*;

    localparam int VOX = SIZE_S * SIZE_L * SIZE_T;
    localparam int AW  = $clog2(VOX);
    localparam int SW  = $clog2(SIZE_S) + 1;
    localparam int LW  = $clog2(SIZE_L) + 1;
    localparam int TW  = $clog2(SIZE_T) + 1;

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_SETUP = 4'd2;
    localparam logic [3:0] ST_SCAN  = 4'd3;
    localparam logic [3:0] ST_WAIT  = 4'd4;
    localparam logic [3:0] ST_SIDE  = 4'd5;
    localparam logic [3:0] ST_OUT   = 4'd6;
    localparam logic [3:0] ST_PLANE = 4'd7;
    localparam logic [3:0] ST_NEXT  = 4'd8;
    localparam logic [3:0] ST_TPASS = 4'd9;

    localparam logic [2:0] SD_SP = 3'd0;
    localparam logic [2:0] SD_SN = 3'd1;
    localparam logic [2:0] SD_LP = 3'd2;
    localparam logic [2:0] SD_LN = 3'd3;
    localparam logic [2:0] SD_TP = 3'd4;
    localparam logic [2:0] SD_SEED = 3'd5;

    logic [3:0] r_state;
    logic [AW-1:0] r_clr;
    logic [6:0] r_sp_step, r_sn_step;
    logic [5:0] r_lp_step, r_ln_step, r_tp_step, r_tspan;
    t_in_item r_it;
    logic [SW-1:0] r_s0, r_s1;
    logic [LW-1:0] r_l0, r_l1;
    logic [TW-1:0] r_t0, r_t1;
    // region under scan
    logic [SW-1:0] r_rs1, r_cs;
    logic [LW-1:0] r_rl0, r_rl1, r_cl;
    logic [TW-1:0] r_rt0, r_rt1, r_ct;
    logic r_hit, r_pend, r_last;
    logic [2:0] r_side;
    logic [6:0] r_cnt;
    logic [3:0] r_fin;
    logic r_blk;

    logic we, rd;
    logic [AW-1:0] waddr, raddr;
    logic wdata;

    function automatic logic [AW-1:0] vidx(input logic [SW-1:0] s,
                                           input logic [LW-1:0] l,
                                           input logic [TW-1:0] t);
        logic [AW+TW+LW+SW-1:0] v;
        begin
            v = ((AW+TW+LW+SW)'(t) * (AW+TW+LW+SW)'(SIZE_L) + (AW+TW+LW+SW)'(l))
                * (AW+TW+LW+SW)'(SIZE_S) + (AW+TW+LW+SW)'(s);
            return v[AW-1:0];
        end
    endfunction

    obi_ram #(.WIDTH(1), .DEPTH(VOX)) u_grid (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rd)
    );

    assign busy = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign raddr = vidx(r_cs, r_cl, r_ct);

    logic in_ok;
    assign in_ok = (32'(r_it.a_s) < SIZE_S) && (32'(r_it.a_l) < SIZE_L)
                && (32'(r_it.a_t) < SIZE_T);

    logic seed_out;
    assign seed_out = 32'(r_it.a_s) >= SIZE_S || 32'(r_it.b_s) >= SIZE_S ||
                      32'(r_it.a_l) >= SIZE_L || 32'(r_it.b_l) >= SIZE_L ||
                      32'(r_it.a_t) >= SIZE_T || 32'(r_it.b_t) >= SIZE_T;

    logic [SW-1:0] sd_s0, sd_s1;
    logic [LW-1:0] sd_l0, sd_l1;
    logic [TW-1:0] sd_t0, sd_t1;
    assign sd_s0 = (r_it.a_s < r_it.b_s) ? SW'(r_it.a_s) : SW'(r_it.b_s);
    assign sd_s1 = (r_it.a_s < r_it.b_s) ? SW'(r_it.b_s) : SW'(r_it.a_s);
    assign sd_l0 = (r_it.a_l < r_it.b_l) ? LW'(r_it.a_l) : LW'(r_it.b_l);
    assign sd_l1 = (r_it.a_l < r_it.b_l) ? LW'(r_it.b_l) : LW'(r_it.a_l);
    assign sd_t0 = (r_it.a_t < r_it.b_t) ? TW'(r_it.a_t) : TW'(r_it.b_t);
    assign sd_t1 = (r_it.a_t < r_it.b_t) ? TW'(r_it.b_t) : TW'(r_it.a_t);

    always_comb begin
        we = 1'b0;
        waddr = r_clr;
        wdata = 1'b0;
        if (r_state == ST_CLR) begin
            we = 1'b1;
        end else if (r_state == ST_SETUP && r_it.func == FUNC_WRITE && in_ok) begin
            we = 1'b1;
            waddr = vidx(SW'(r_it.a_s), LW'(r_it.a_l), TW'(r_it.a_t));
            wdata = r_it.occupied;
        end
    end

    // step count for a side, zero acts as one
    function automatic logic [6:0] stp(input logic [6:0] v);
        return (v == 7'd0) ? 7'd1 : v;
    endfunction

    logic [6:0] side_step;
    always_comb begin
        case (r_side)
            SD_SP:   side_step = stp(r_sp_step);
            SD_SN:   side_step = stp(r_sn_step);
            SD_LP:   side_step = stp({1'b0, r_lp_step});
            SD_LN:   side_step = stp({1'b0, r_ln_step});
            default: side_step = stp({1'b0, r_tp_step});
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp_step <= 7'd1; r_sn_step <= 7'd1;
            r_lp_step <= 6'd1; r_ln_step <= 6'd1; r_tp_step <= 6'd1;
            r_tspan <= 6'd8;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_STEP_S_POS: r_sp_step <= i_cfg_data;
                REG_STEP_S_NEG: r_sn_step <= i_cfg_data;
                REG_STEP_L_POS: r_lp_step <= i_cfg_data[5:0];
                REG_STEP_L_NEG: r_ln_step <= i_cfg_data[5:0];
                REG_STEP_T_POS: r_tp_step <= i_cfg_data[5:0];
                REG_MAX_TSPAN:  r_tspan   <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // next candidate plane for side r_side, flagged when it leaves the grid
    logic [SW-1:0] np_s;
    logic [LW-1:0] np_l;
    logic [TW-1:0] np_t;
    logic np_out;
    always_comb begin
        np_s = '0; np_l = '0; np_t = '0; np_out = 1'b0;
        case (r_side)
            SD_SP: begin np_s = r_s1 + 1'b1; np_out = 32'(np_s) >= SIZE_S; end
            SD_SN: begin np_s = r_s0 - 1'b1; np_out = (r_s0 == '0); end
            SD_LP: begin np_l = r_l1 + 1'b1; np_out = 32'(np_l) >= SIZE_L; end
            SD_LN: begin np_l = r_l0 - 1'b1; np_out = (r_l0 == '0); end
            default: begin np_t = r_t1 + 1'b1; np_out = 32'(np_t) >= SIZE_T; end
        endcase
    end

    // next side in round order; at the end of a round apply the s limits
    logic [3:0] lim_fin;
    logic [2:0] nxt_side;
    logic nxt_wrap;
    always_comb begin
        lim_fin = r_fin;
        if (32'(r_s1) >= 32'(r_it.s_upper_limit)) lim_fin[0] = 1'b1;
        if (32'(r_s0) <= 32'(r_it.s_lower_limit)) lim_fin[1] = 1'b1;
        nxt_wrap = 1'b0;
        case (r_side)
            SD_SP: nxt_side = !r_fin[1] ? SD_SN : (!r_fin[2] ? SD_LP :
                              (!r_fin[3] ? SD_LN : SD_TP));
            SD_SN: nxt_side = !r_fin[2] ? SD_LP : (!r_fin[3] ? SD_LN : SD_TP);
            SD_LP: nxt_side = !r_fin[3] ? SD_LN : SD_TP;
            default: nxt_side = SD_TP;
        endcase
        if (nxt_side == SD_TP) begin
            nxt_wrap = 1'b1;
            nxt_side = !lim_fin[0] ? SD_SP : (!lim_fin[1] ? SD_SN :
                       (!lim_fin[2] ? SD_LP : (!lim_fin[3] ? SD_LN : SD_TP)));
        end
    end

    logic scan_end;
    assign scan_end = (r_cs == r_rs1) && (r_cl == r_rl1) && (r_ct == r_rt1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= (r_state == ST_OUT);
            case (r_state)
                ST_CLR: begin
                    if (32'(r_clr) == VOX - 1) begin
                        r_clr <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (start) begin
                        r_it <= i_item;
                        r_state <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    r_s0 <= sd_s0; r_s1 <= sd_s1;
                    r_l0 <= sd_l0; r_l1 <= sd_l1;
                    r_t0 <= sd_t0; r_t1 <= sd_t1;
                    r_rs1 <= sd_s1;
                    r_rl0 <= sd_l0; r_rl1 <= sd_l1;
                    r_rt0 <= sd_t0; r_rt1 <= sd_t1;
                    r_cs <= sd_s0; r_cl <= sd_l0; r_ct <= sd_t0;
                    r_hit <= 1'b0; r_pend <= 1'b0; r_last <= 1'b0;
                    r_side <= SD_SEED;
                    r_fin <= '0;
                    r_cnt <= '0;
                    r_blk <= (r_it.func == FUNC_INFLATE) && seed_out;
                    case (r_it.func)
                        FUNC_INFLATE: r_state <= seed_out ? ST_OUT : ST_SCAN;
                        FUNC_CLEAR:   r_state <= ST_CLR;
                        default:      r_state <= ST_IDLE;
                    endcase
                end
                ST_SCAN: begin
                    // issue reads voxel by voxel, stop early on an occupied one
                    r_pend <= 1'b1;
                    if (r_pend && rd) begin
                        r_hit <= 1'b1;
                        r_state <= ST_SIDE;
                    end else if (scan_end) begin
                        r_state <= ST_WAIT;
                    end else if (r_ct != r_rt1) begin
                        r_ct <= r_ct + 1'b1;
                    end else begin
                        r_ct <= r_rt0;
                        if (r_cl != r_rl1) begin
                            r_cl <= r_cl + 1'b1;
                        end else begin
                            r_cl <= r_rl0;
                            r_cs <= r_cs + 1'b1;
                        end
                    end
                end
                ST_WAIT: begin
                    r_hit <= (r_pend && rd);
                    r_pend <= 1'b0;
                    r_state <= ST_SIDE;
                end
                ST_SIDE: begin
                    r_hit <= 1'b0;
                    r_last <= 1'b0;
                    r_pend <= 1'b0;
                    if (r_side == SD_SEED) begin
                        if (r_hit) begin
                            r_blk <= 1'b1;
                            r_state <= ST_OUT;
                        end else begin
                            r_side <= SD_SP;
                            r_cnt <= '0;
                            r_state <= ST_PLANE;
                        end
                    end else if (r_hit || r_last) begin
                        r_cnt <= '0;
                        case (r_side)
                            SD_SP:   r_fin[0] <= 1'b1;
                            SD_SN:   r_fin[1] <= 1'b1;
                            SD_LP:   r_fin[2] <= 1'b1;
                            SD_LN:   r_fin[3] <= 1'b1;
                            default: ;
                        endcase
                        r_state <= (r_side == SD_TP) ? ST_OUT : ST_NEXT;
                    end else begin
                        case (r_side)
                            SD_SP:   r_s1 <= r_s1 + 1'b1;
                            SD_SN:   r_s0 <= r_s0 - 1'b1;
                            SD_LP:   r_l1 <= r_l1 + 1'b1;
                            SD_LN:   r_l0 <= r_l0 - 1'b1;
                            default: r_t1 <= r_t1 + 1'b1;
                        endcase
                        if (r_cnt + 1'b1 >= side_step) begin
                            r_cnt <= '0;
                            r_state <= (r_side == SD_TP) ? ST_TPASS : ST_NEXT;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                            r_state <= ST_PLANE;
                        end
                    end
                end
                ST_PLANE: begin
                    // set up the region of the next plane for r_side
                    r_rs1 <= (r_side == SD_SP || r_side == SD_SN) ? np_s : r_s1;
                    r_rl0 <= (r_side == SD_LP || r_side == SD_LN) ? np_l : r_l0;
                    r_rl1 <= (r_side == SD_LP || r_side == SD_LN) ? np_l : r_l1;
                    r_rt0 <= (r_side == SD_TP) ? np_t : r_t0;
                    r_rt1 <= (r_side == SD_TP) ? np_t : r_t1;
                    r_cs <= (r_side == SD_SP || r_side == SD_SN) ? np_s : r_s0;
                    r_cl <= (r_side == SD_LP || r_side == SD_LN) ? np_l : r_l0;
                    r_ct <= (r_side == SD_TP) ? np_t : r_t0;
                    r_pend <= 1'b0;
                    if (np_out) begin
                        r_last <= 1'b1;
                        r_state <= ST_SIDE;
                    end else begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_NEXT: begin
                    r_side <= nxt_side;
                    if (nxt_wrap) begin
                        r_fin <= lim_fin;
                    end
                    r_state <= ST_PLANE;
                end
                ST_TPASS: begin
                    if (32'(r_t1) - 32'(r_t0) >= 32'(r_tspan)) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_PLANE;
                    end
                end
                ST_OUT: begin
                    o_result.box_s_low <= 6'(r_s0);
                    o_result.box_s_high <= 6'(r_s1);
                    o_result.box_l_low <= 5'(r_l0);
                    o_result.box_l_high <= 5'(r_l1);
                    o_result.box_t_low <= 5'(r_t0);
                    o_result.box_t_high <= 5'(r_t1);
                    o_result.seed_blocked <= r_blk;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

>>> src/obi_checker.sv
// ----------------------------------------------------------------------------
// obi_checker
// Port-level checks on the occupancy box inflation block.
// ----------------------------------------------------------------------------
`include "occupancy_box_inflation_top_assert.svh"
module obi_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_done,
    input obi_pkg::t_out_item o_result
);
    import obi_pkg::*;

    logic box_ordered;
    assign box_ordered = (o_result.box_s_low <= o_result.box_s_high)
                      && (o_result.box_l_low <= o_result.box_l_high);

    `OBI_ASSERT_NXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `OBI_ASSERT_NXT(a_take_busy, i_clk, i_rst_n, start && !busy, busy)
    `OBI_ASSERT_IMP(a_box_order, i_clk, i_rst_n, o_done && !o_result.seed_blocked, box_ordered)
endmodule

bind occupancy_box_inflation_top obi_checker u_obi_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_result(o_result)
);

>>> tb/tb_occupancy_box_inflation_top.sv
// ----------------------------------------------------------------------------
// tb_occupancy_box_inflation_top
// Self-checking bench for the occupancy box inflation block.
// ----------------------------------------------------------------------------
// A directed table covers reset values, grid extremes, blocked seeds, the
// unused function code and a clear. Random phases then run under several
// register settings on a randomly written grid. Every inflate transfer is
// predicted from a local copy of the grid and registers, or taken from the
// table for typed rows, and compared with the result strobed on o_done.
// ----------------------------------------------------------------------------
module tb_occupancy_box_inflation_top;
    import obi_pkg::*;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item res;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_in_item   i_item = '0;
    logic       o_done;
    t_out_item  o_result;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [6:0] i_cfg_data = '0;

    bit         occ_grid [SizeS*SizeL*SizeT];
    bit [6:0]   cfg_reg [6];
    t_out_item  box_queue [$];
    int         err_count = 0;
    int         cycle_count = 0;
    t_row       rows [$];

    occupancy_box_inflation_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 60000000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic bit voxel_free(int s, int l, int t);
        if (s < 0 || s >= SizeS || l < 0 || l >= SizeL || t < 0 || t >= SizeT) begin
            return 1'b0;
        end
        return !occ_grid[(t * SizeL + l) * SizeS + s];
    endfunction

    function automatic bit region_free(int lo[3], int hi[3]);
        for (int s = lo[0]; s <= hi[0]; s++)
            for (int l = lo[1]; l <= hi[1]; l++)
                for (int t = lo[2]; t <= hi[2]; t++)
                    if (!voxel_free(s, l, t)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic int step_count(bit [6:0] v);
        return (v == 0) ? 1 : int'(v);
    endfunction

    function automatic bit grow_face(inout int lo[3], inout int hi[3], input int ax,
                                     input bit up, input int steps, input int size);
        int p;
        int rl[3];
        int rh[3];
        for (int i = 0; i < steps; i++) begin
            p = up ? hi[ax] + 1 : lo[ax] - 1;
            if (p < 0 || p >= size) return 1'b1;
            rl = lo;
            rh = hi;
            rl[ax] = p;
            rh[ax] = p;
            if (!region_free(rl, rh)) return 1'b1;
            if (up) hi[ax] = p;
            else lo[ax] = p;
        end
        return 1'b0;
    endfunction

    function automatic t_out_item inflate_box(t_in_item it);
        int lo[3];
        int hi[3];
        bit sp, sn, lp, ln, tp, blk;
        t_out_item r;
        lo[0] = (it.a_s < it.b_s) ? it.a_s : it.b_s;
        hi[0] = (it.a_s < it.b_s) ? it.b_s : it.a_s;
        lo[1] = (it.a_l < it.b_l) ? it.a_l : it.b_l;
        hi[1] = (it.a_l < it.b_l) ? it.b_l : it.a_l;
        lo[2] = (it.a_t < it.b_t) ? it.a_t : it.b_t;
        hi[2] = (it.a_t < it.b_t) ? it.b_t : it.a_t;
        blk = !region_free(lo, hi);
        if (!blk) begin
            sp = 0; sn = 0; lp = 0; ln = 0; tp = 0;
            while (!(sp && sn && lp && ln)) begin
                if (!sp) sp = grow_face(lo, hi, 0, 1, step_count(cfg_reg[0]), SizeS);
                if (!sn) sn = grow_face(lo, hi, 0, 0, step_count(cfg_reg[1]), SizeS);
                if (!lp) lp = grow_face(lo, hi, 1, 1, step_count(cfg_reg[2]), SizeL);
                if (!ln) ln = grow_face(lo, hi, 1, 0, step_count(cfg_reg[3]), SizeL);
                if (hi[0] >= int'(it.s_upper_limit)) sp = 1;
                if (lo[0] <= int'(it.s_lower_limit)) sn = 1;
            end
            while (!tp) begin
                tp = grow_face(lo, hi, 2, 1, step_count(cfg_reg[4]), SizeT);
                if (hi[2] - lo[2] >= int'(cfg_reg[5])) tp = 1;
            end
        end
        r.box_s_low    = lo[0][5:0];
        r.box_s_high   = hi[0][5:0];
        r.box_l_low    = lo[1][4:0];
        r.box_l_high   = hi[1][4:0];
        r.box_t_low    = lo[2][4:0];
        r.box_t_high   = hi[2][4:0];
        r.seed_blocked = blk;
        return r;
    endfunction

    function automatic t_in_item mk(logic [1:0] f, int as, int al, int at, int bs, int bl,
                                    int bt, bit occ, int su, int sl);
        t_in_item it;
        it.func = f;
        it.a_s = 6'(as); it.a_l = 5'(al); it.a_t = 5'(at);
        it.b_s = 6'(bs); it.b_l = 5'(bl); it.b_t = 5'(bt);
        it.occupied = occ;
        it.s_upper_limit = 7'(su);
        it.s_lower_limit = 6'(sl);
        return it;
    endfunction

    function automatic t_out_item box(int sl, int sh, int ll, int lh, int tl, int th, bit b);
        t_out_item r;
        r = {sl[5:0], sh[5:0], ll[4:0], lh[4:0], tl[4:0], th[4:0], b};
        return r;
    endfunction

    task automatic add_row(t_in_item it, bit typed = 0, t_out_item r = '0);
        t_row w;
        w.item = it;
        w.typed = typed;
        w.res = r;
        rows = {rows, w};
    endtask

    task automatic send(t_in_item it, bit typed = 0, t_out_item r = '0);
        t_out_item exp_box;
        @(negedge i_clk);
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        case (it.func)
            FUNC_WRITE:   occ_grid[(it.a_t * SizeL + it.a_l) * SizeS + it.a_s] = it.occupied;
            FUNC_CLEAR:   occ_grid = '{default: 1'b0};
            FUNC_INFLATE: begin
                exp_box = typed ? r : inflate_box(it);
                box_queue = {box_queue, exp_box};
            end
            default: ;
        endcase
    endtask

    task automatic hold_off(int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_idle();
        hold_off(0);
        while (box_queue.size() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (busy);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, bit [6:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_STEP_S_POS, REG_STEP_S_NEG: cfg_reg[idx] = val;
            REG_STEP_L_POS, REG_STEP_L_NEG, REG_STEP_T_POS, REG_MAX_TSPAN:
                cfg_reg[idx] = val & 7'h3f;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_done) begin
            if (box_queue.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_result);
                err_count++;
            end else begin
                e = box_queue.pop_front();
                if (o_result.box_s_low !== e.box_s_low || o_result.box_s_high !== e.box_s_high
                    || o_result.box_l_low !== e.box_l_low
                    || o_result.box_l_high !== e.box_l_high
                    || o_result.box_t_low !== e.box_t_low
                    || o_result.box_t_high !== e.box_t_high
                    || o_result.seed_blocked !== e.seed_blocked) begin
                    $display("%0t: box mismatch, expected %h, actual %h", $time, e, o_result);
                    err_count++;
                end
            end
        end
    end

    initial begin
        int n, s, l, t, burst;
        bit [6:0] settings [5][6];
        t_in_item it;
        settings = '{'{7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd8},
                     '{7'd64, 7'd64, 7'd32, 7'd32, 7'd32, 7'd32},
                     '{7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0},
                     '{7'd3, 7'd5, 7'd2, 7'd7, 7'd4, 7'd5},
                     '{7'd127, 7'd64, 7'd63, 7'd1, 7'd3, 7'd63}};
        cfg_reg = '{7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd8};
        occ_grid = '{default: 1'b0};
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_row(mk(FUNC_INFLATE, 0, 0, 0, 0, 0, 0, 0, 64, 0), 1, box(0, 63, 0, 31, 0, 8, 0));
        add_row(mk(FUNC_WRITE, 5, 5, 5, 0, 0, 0, 1, 0, 0));
        add_row(mk(FUNC_INFLATE, 5, 5, 5, 5, 5, 5, 0, 0, 0), 1, box(5, 5, 5, 5, 5, 5, 1));
        add_row(mk(FUNC_WRITE, 63, 31, 31, 0, 0, 0, 1, 0, 0));
        add_row(mk(FUNC_INFLATE, 63, 31, 31, 0, 0, 0, 0, 64, 0), 1,
                box(0, 63, 0, 31, 0, 31, 1));
        add_row(mk(2'd3, 1, 1, 1, 2, 2, 2, 1, 64, 0));
        add_row(mk(FUNC_INFLATE, 10, 10, 0, 12, 12, 2, 0, 20, 8));
        add_row(mk(FUNC_INFLATE, 40, 3, 20, 40, 3, 20, 0, 0, 63));
        add_row(mk(FUNC_INFLATE, 6, 5, 5, 6, 5, 5, 0, 64, 0));
        add_row(mk(FUNC_WRITE, 5, 5, 5, 0, 0, 0, 0, 0, 0));
        add_row(mk(FUNC_INFLATE, 20, 20, 20, 30, 25, 22, 0, 40, 15));
        add_row(mk(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk(FUNC_INFLATE, 63, 31, 31, 63, 31, 31, 0, 64, 0), 1,
                box(0, 63, 0, 31, 31, 31, 0));
        foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].res);

        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            for (int r = 0; r < 6; r++) cfg_write(r[2:0], settings[ph][r]);
            if (ph == 1) send(mk(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
            for (int k = 0; k < 10; k++) begin
                send(mk(FUNC_WRITE, $urandom_range(0, 63), $urandom_range(0, 31),
                        $urandom_range(0, 31), 0, 0, 0, ($urandom_range(0, 9) < 8), 0, 0));
            end
            n = 0;
            while (n < 8) begin
                burst = $urandom_range(1, 6);
                for (int b = 0; b < burst; b++) begin
                    s = $urandom_range(0, 63);
                    l = $urandom_range(0, 31);
                    t = $urandom_range(0, 31);
                    case ($urandom_range(0, 9))
                        0, 1, 2: it = mk(FUNC_WRITE, s, l, t, 0, 0, 0, $urandom_range(0, 3) != 0,
                                         $urandom_range(0, 64), $urandom_range(0, 63));
                        3: it = mk(2'd3, s, l, t, $urandom_range(0, 63), $urandom_range(0, 31),
                                   $urandom_range(0, 31), 1'($urandom), $urandom_range(0, 64),
                                   $urandom_range(0, 63));
                        default: begin
                            it = mk(FUNC_INFLATE, s, l, t,
                                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                               : (s + $urandom_range(0, 2)) % 64,
                                    (l + $urandom_range(0, 1)) % 32,
                                    (t + $urandom_range(0, 1)) % 32, 1'($urandom),
                                    $urandom_range(0, 64), $urandom_range(0, 63));
                            n++;
                        end
                    endcase
                    send(it);
                end
                if ($urandom_range(0, 2) != 0) hold_off($urandom_range(0, 12));
            end
        end

        wait_idle();
        if (err_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+src
src/obi_pkg.sv
src/obi_ram.sv
src/occupancy_box_inflation_top.sv
src/obi_checker.sv
tb/tb_occupancy_box_inflation_top.sv
